>>> rtl/ltf_pkg.sv
// ----------------------------------------------------------------------------
// ltf_pkg
// Shared types, constants and helpers of the LED twinkle fader.
// ----------------------------------------------------------------------------
package ltf_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int STRIP_MAX_DEF  = 1024;

  localparam int LED_W   = 10;
  localparam int LEVEL_W = 8;
  localparam int NLEDS_W = 11;
  localparam int TICK_W  = 8;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [LEVEL_W-1:0] LIT_LEVEL = 8'd250;
  localparam logic [TICK_W-1:0]  TICK_MAX  = 8'd255;

  localparam logic [NLEDS_W-1:0] NUM_LEDS_RST     = 11'd60;
  localparam logic [LEVEL_W-1:0] FADE_STEP_RST    = 8'd8;
  localparam logic [TICK_W-1:0]  SPAWN_PERIOD_RST = 8'd10;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_NUM_LEDS     = 2'd0,
    REG_FADE_STEP    = 2'd1,
    REG_SPAWN_PERIOD = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHOW
  } state_t;

  typedef struct packed {
    logic [LED_W-1:0] candidate_led;
    logic             rand_red;
    logic             rand_green;
    logic             rand_blue;
  } in_item_t;

  typedef struct packed {
    logic [LED_W-1:0]   led_index;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic               is_show;
  } out_item_t;

  typedef struct packed {
    logic               busy;
    logic [LED_W-1:0]   led;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } slot_t;

  // Saturating subtract of the fade step.
  function automatic logic [LEVEL_W-1:0] fade_level(input logic [LEVEL_W-1:0] level,
                                                    input logic [LEVEL_W-1:0] step);
    fade_level = (level >= step) ? (level - step) : '0;
  endfunction

endpackage

>>> rtl/ltf_cell.sv
// ----------------------------------------------------------------------------
// ltf_cell
// One slot of the ring: takes its neighbor's slot on a shift, or a new
// slot on a spawn load.
// ----------------------------------------------------------------------------
module ltf_cell
  import ltf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift_en,
  input  logic  load_en,
  input  slot_t shift_in,
  input  slot_t load_in,
  output slot_t slot_q
);

  slot_t slot_r;
  slot_t slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (load_en) begin
      slot_nxt = load_in;
    end else if (shift_en) begin
      slot_nxt = shift_in;
    end
  end

  // Reset leaves the slot free and black.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_q = slot_r;

endmodule

>>> rtl/led_twinkle_fader_core.sv
// ----------------------------------------------------------------------------
// led_twinkle_fader_core
// Twinkle animation engine: fades lit slots each tick and spawns new ones.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                             | One beat carries
//  ---------+-----------------------------------+------------------------------
//  input    | in_valid, in_stall, in_data       | one animation tick
//  output   | out_valid, out_stall, out_data    | one pixel update or the show
//  config   | psel, penable, pwrite, paddr, ... | one register write or read
//
// A tick is accepted in ST_IDLE; in ST_SCAN the ring of cells rotates by one
// position per slot; ST_SHOW sends the show beat, in which a spawn is committed.
// Stalls on the output hold the ring. Reset is synchronous on rst_n and frees
// every slot, clears the tick count and loads the register defaults. in_stall
// is high while a tick is in work.
//
// The slots live in a ring of identical cells. Each scan cycle that the output
// is free, the cell at the head is faded, its pixel update is written to the
// output register if it is busy, and it re-enters the ring at the tail. After
// SLOT_COUNT steps every slot is back at its own cell. During the scan the first
// free slot and any busy slot already holding the candidate LED are noted, so the
// spawn decision is ready when the show beat goes out.
// ----------------------------------------------------------------------------
module led_twinkle_fader_core
  import ltf_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int STRIP_MAX  = STRIP_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  // output channel
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [NLEDS_W-1:0] STRIP_LIM = NLEDS_W'(STRIP_MAX);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [NLEDS_W-1:0] num_leds_r;
  logic [LEVEL_W-1:0] fade_step_r;
  logic [TICK_W-1:0]  spawn_period_r;
  reg_idx_t           reg_sel;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_leds_r     <= NUM_LEDS_RST;
      fade_step_r    <= FADE_STEP_RST;
      spawn_period_r <= SPAWN_PERIOD_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_NUM_LEDS:     num_leds_r     <= pwdata[NLEDS_W-1:0];
        REG_FADE_STEP:    fade_step_r    <= pwdata[LEVEL_W-1:0];
        REG_SPAWN_PERIOD: spawn_period_r <= pwdata[TICK_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_NUM_LEDS:     prdata = DATA_W'(num_leds_r);
      REG_FADE_STEP:    prdata = DATA_W'(fade_step_r);
      REG_SPAWN_PERIOD: prdata = DATA_W'(spawn_period_r);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Ring of slot cells
  // --------------------------------------------------------------------------
  slot_t cell_q [SLOT_COUNT];
  slot_t head_new;
  slot_t spawn_slot;
  logic  shift_en;
  logic  load_any;

  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] ff_idx_r, ff_idx_nxt;
  logic             ff_found_r, ff_found_nxt;
  logic             in_use_r, in_use_nxt;

  for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
    ltf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .load_en  (load_any && (ff_idx_r == IDX_W'(k))),
      .shift_in ((k == SLOT_COUNT - 1) ? head_new : cell_q[(k + 1) % SLOT_COUNT]),
      .load_in  (spawn_slot),
      .slot_q   (cell_q[k])
    );
  end

  // The head slot after this tick's fade; a busy slot that reaches black is
  // released here.
  always_comb begin
    head_new = cell_q[0];
    if (cell_q[0].busy) begin
      head_new.red   = fade_level(cell_q[0].red, fade_step_r);
      head_new.green = fade_level(cell_q[0].green, fade_step_r);
      head_new.blue  = fade_level(cell_q[0].blue, fade_step_r);
      head_new.busy  = (head_new.red != '0) || (head_new.green != '0) ||
                       (head_new.blue != '0);
    end
  end

  // --------------------------------------------------------------------------
  // Tick control
  // --------------------------------------------------------------------------
  state_t    state_r, state_nxt;
  in_item_t  item_r;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      out_free;
  logic      in_acc;
  logic      cand_ok;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cand_ok  = ({1'b0, item_r.candidate_led} < num_leds_r) &&
                    ({1'b0, item_r.candidate_led} < STRIP_LIM) && !in_use_r;

  always_comb begin
    spawn_slot.busy  = 1'b1;
    spawn_slot.led   = item_r.candidate_led;
    spawn_slot.red   = item_r.rand_red   ? LIT_LEVEL : '0;
    spawn_slot.green = item_r.rand_green ? LIT_LEVEL : '0;
    spawn_slot.blue  = item_r.rand_blue  ? LIT_LEVEL : '0;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ff_idx_nxt    = ff_idx_r;
    ff_found_nxt  = ff_found_r;
    in_use_nxt    = in_use_r;
    tick_nxt      = tick_r;
    shift_en      = 1'b0;
    load_any      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt    = ST_SCAN;
          cnt_nxt      = '0;
          ff_found_nxt = 1'b0;
          ff_idx_nxt   = '0;
          in_use_nxt   = 1'b0;
          if (tick_r != TICK_MAX) begin
            tick_nxt = tick_r + 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          shift_en = 1'b1;
          if (cell_q[0].busy) begin
            out_valid_nxt          = 1'b1;
            out_data_nxt.led_index = head_new.led;
            out_data_nxt.red       = head_new.red;
            out_data_nxt.green     = head_new.green;
            out_data_nxt.blue      = head_new.blue;
            out_data_nxt.is_show   = 1'b0;
          end
          if (!head_new.busy && !ff_found_r) begin
            ff_found_nxt = 1'b1;
            ff_idx_nxt   = cnt_r;
          end
          if (head_new.busy && (head_new.led == item_r.candidate_led)) begin
            in_use_nxt = 1'b1;
          end
          if (cnt_r == LAST_IDX) begin
            state_nxt = ST_SHOW;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_SHOW: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.is_show = 1'b1;
          state_nxt     = ST_IDLE;
          if (tick_r >= spawn_period_r) begin
            if (!ff_found_r) begin
              tick_nxt = '0;
            end else if (cand_ok) begin
              load_any = 1'b1;
              tick_nxt = '0;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      ff_found_r  <= 1'b0;
      in_use_r    <= 1'b0;
      ff_idx_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      ff_found_r  <= ff_found_nxt;
      in_use_r    <= in_use_nxt;
      ff_idx_r    <= ff_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_acc) begin
      item_r <= in_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED twinkle fader core.
//
// Animation ticks go in one beat at a time. A behavioral copy of the slot
// table, updated at every accepted tick, queues the pixel updates and the
// show beat that the core must produce. Each accepted output beat is checked
// field by field against the head of that queue. Register writes go through
// the configuration port while the core is idle and are read back.
// ----------------------------------------------------------------------------
module tb_top;
  import ltf_pkg::*;

  localparam int SLOTS       = SLOT_COUNT_DEF;
  localparam int STRIP       = STRIP_MAX_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_TAIL  = 2 * SLOTS + 8;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  led_twinkle_fader_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Mirror of the register file, as the core should hold it.
  logic [NLEDS_W-1:0] strip_len;
  logic [LEVEL_W-1:0] fade_amt;
  logic [TICK_W-1:0]  spawn_gap;

  // Mirror of the slot table and the tick counter.
  logic               lit     [SLOTS];
  logic [LED_W-1:0]   lit_led [SLOTS];
  logic [LEVEL_W-1:0] lvl_red [SLOTS];
  logic [LEVEL_W-1:0] lvl_grn [SLOTS];
  logic [LEVEL_W-1:0] lvl_blu [SLOTS];
  logic [TICK_W-1:0]  ticks_since_spawn;

  // Pixel updates and show beats still owed by the core, oldest first.
  out_item_t pixel_q[$];

  int mismatches   = 0;
  int cycles       = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  // --------------------------------------------------------------------------
  // Clock and cycle budget. The budget is far above the slowest legal run,
  // so hitting it means the core has hung.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL led_twinkle_fader_core");
      $finish;
    end
  end

  // The output side stalls at random; the percentage changes per phase.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Predictor. Called once per accepted tick: fades every lit slot in slot
  // order, queues its pixel update, frees it once black, queues the show beat
  // and finally decides on a spawn. A spawned slot is only seen next tick.
  // --------------------------------------------------------------------------
  function automatic logic [LEVEL_W-1:0] dimmed(input logic [LEVEL_W-1:0] lvl);
    return (lvl > fade_amt) ? lvl - fade_amt : '0;
  endfunction

  function automatic void advance_tick(input in_item_t t);
    out_item_t px;
    int        free_idx;
    logic      taken;
    free_idx = -1;
    taken    = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (lit[i]) begin
        lvl_red[i]   = dimmed(lvl_red[i]);
        lvl_grn[i]   = dimmed(lvl_grn[i]);
        lvl_blu[i]   = dimmed(lvl_blu[i]);
        px.led_index = lit_led[i];
        px.red       = lvl_red[i];
        px.green     = lvl_grn[i];
        px.blue      = lvl_blu[i];
        px.is_show   = 1'b0;
        pixel_q.push_back(px);
        if (lvl_red[i] == '0 && lvl_grn[i] == '0 && lvl_blu[i] == '0)
          lit[i] = 1'b0;
      end
    end
    px         = '0;
    px.is_show = 1'b1;
    pixel_q.push_back(px);

    if (ticks_since_spawn != TICK_MAX)
      ticks_since_spawn++;
    if (ticks_since_spawn >= spawn_gap) begin
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!lit[i])
          free_idx = i;
        if (lit[i] && lit_led[i] == t.candidate_led)
          taken = 1'b1;
      end
      if (free_idx < 0) begin
        ticks_since_spawn = '0;
      end else if ({1'b0, t.candidate_led} < strip_len && t.candidate_led < STRIP && !taken) begin
        lit[free_idx]     = 1'b1;
        lit_led[free_idx] = t.candidate_led;
        lvl_red[free_idx] = t.rand_red ? LIT_LEVEL : '0;
        lvl_grn[free_idx] = t.rand_green ? LIT_LEVEL : '0;
        lvl_blu[free_idx] = t.rand_blue ? LIT_LEVEL : '0;
        ticks_since_spawn = '0;
      end
      // Otherwise the spawn is deferred and the tick count is kept.
    end
  endfunction

  // --------------------------------------------------------------------------
  // Output checker. Every accepted output beat must match the oldest owed
  // beat; a beat with nothing owed is a failure as well.
  // --------------------------------------------------------------------------
  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", fname, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : pixel_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected output beat: led_index %0d is_show %0b",
               out_data.led_index, out_data.is_show);
        mismatches++;
      end else begin
        want = pixel_q.pop_front();
        check_field("led_index", want.led_index, out_data.led_index);
        check_field("red",       want.red,       out_data.red);
        check_field("green",     want.green,     out_data.green);
        check_field("blue",      want.blue,      out_data.blue);
        check_field("is_show",   want.is_show,   out_data.is_show);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side. All driving tasks are entered and left at a falling edge,
  // so no signal ever gets two assignments in one time step. Valid stays
  // high from one beat to the next unless an idle cycle is drawn.
  // --------------------------------------------------------------------------
  task automatic send_tick(input in_item_t t);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    advance_tick(t);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every owed beat has come out and the core
  // will take a new tick again. Register writes are only made after this.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pixel_q.size() != 0 || in_stall);
  endtask

  // --------------------------------------------------------------------------
  // Configuration port: a setup phase, an access phase, then psel is dropped.
  // Every write is read back through the same port.
  // --------------------------------------------------------------------------
  task automatic cfg_read(input reg_idx_t idx, input logic [DATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field(idx.name(), want, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] held;
    held = '0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_NUM_LEDS: begin
        strip_len = val[NLEDS_W-1:0];
        held      = DATA_W'(strip_len);
      end
      REG_FADE_STEP: begin
        fade_amt = val[LEVEL_W-1:0];
        held     = DATA_W'(fade_amt);
      end
      REG_SPAWN_PERIOD: begin
        spawn_gap = val[TICK_W-1:0];
        held      = DATA_W'(spawn_gap);
      end
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    cfg_read(idx, held);
  endtask

  task automatic set_all(input int leds, input int step, input int gap);
    set_reg(REG_NUM_LEDS, leds);
    set_reg(REG_FADE_STEP, step);
    set_reg(REG_SPAWN_PERIOD, gap);
  endtask

  function automatic in_item_t make_tick(input int led, input logic [2:0] rgb);
    in_item_t t;
    t.candidate_led = LED_W'(led);
    {t.rand_red, t.rand_green, t.rand_blue} = rgb;
    return t;
  endfunction

  // Most candidates fall on the strip so that spawns actually happen; the
  // rest cover the whole index range, off-strip ones included.
  function automatic in_item_t rand_tick();
    int unsigned span;
    in_item_t    t;
    span = (strip_len > STRIP) ? STRIP : strip_len;
    if ($urandom_range(0, 4) != 0 && span != 0)
      t.candidate_led = LED_W'($urandom_range(0, span - 1));
    else
      t.candidate_led = LED_W'($urandom);
    {t.rand_red, t.rand_green, t.rand_blue} = 3'($urandom);
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset defaults read back, then each register at its maximum and at one.
  task automatic test_registers();
    cfg_read(REG_NUM_LEDS, DATA_W'(NUM_LEDS_RST));
    cfg_read(REG_FADE_STEP, DATA_W'(FADE_STEP_RST));
    cfg_read(REG_SPAWN_PERIOD, DATA_W'(SPAWN_PERIOD_RST));
    set_all(2047, 255, 255);
    set_all(1, 1, 1);
  endtask

  // One spawn per tick over all eight colour mixes, the black one among
  // them, with candidates at both ends of the index range. A fade of 125
  // retires each lit slot after two ticks.
  task automatic test_spawn_colours();
    int leds[8] = '{0, 1023, 513, 300, 7, 1022, 64, 1};
    set_all(1024, 125, 1);
    for (int i = 0; i < 8; i++)
      send_tick(make_tick(leds[i], 3'(i)));
    wait_idle();
  endtask

  // Spawns that must wait: a candidate already lit, one at or past the
  // strip length, and a strip length of zero. A full-width strip length
  // then lets the highest index in.
  task automatic test_deferred_spawn();
    set_all(1, 1, 1);
    send_tick(make_tick(0, 3'b100));
    send_tick(make_tick(0, 3'b011));
    send_tick(make_tick(1, 3'b111));
    send_tick(make_tick(1023, 3'b111));
    wait_idle();
    set_reg(REG_NUM_LEDS, 0);
    send_tick(make_tick(0, 3'b001));
    wait_idle();
    set_reg(REG_NUM_LEDS, 2047);
    send_tick(make_tick(1023, 3'b010));
    wait_idle();
    set_reg(REG_FADE_STEP, 255);
    send_tick(make_tick(5, 3'b000));
    wait_idle();
  endtask

  // With no fade, lit slots hold their colour and only a black spawn is
  // freed; with a zero period a spawn is tried every tick.
  task automatic test_no_fade();
    set_all(1024, 0, 0);
    send_tick(make_tick(10, 3'b111));
    send_tick(make_tick(11, 3'b000));
    send_tick(make_tick(12, 3'b010));
    send_tick(make_tick(13, 3'b101));
    wait_idle();
    set_reg(REG_FADE_STEP, 255);
    send_tick(make_tick(14, 3'b000));
    send_tick(make_tick(15, 3'b000));
    wait_idle();
  endtask

  // Random ticks; now and then the sender holds back until the core has
  // delivered every owed beat.
  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0)
        wait_idle();
      send_tick(rand_tick());
    end
    wait_idle();
  endtask

  // Slow fade and a spawn every tick fill all slots, so ticks carry the
  // most pixel updates and spawns meet a full table.
  task automatic test_busy_strip();
    snd_idle_pct = 28;
    rcv_idle_pct = 49;
    set_all(1024, 3, 1);
    run_random(50);
  endtask

  // A tiny strip makes lit-candidate collisions common.
  task automatic test_crowded_strip();
    snd_idle_pct = 49;
    rcv_idle_pct = 28;
    set_all(6, 40, 2);
    run_random(50);
  endtask

  // Back-to-back beats under a string of random settings, the longest
  // spawn period last.
  task automatic test_random_settings();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    for (int k = 0; k < 3; k++) begin
      set_all($urandom_range(1, 1024), $urandom_range(1, 255), $urandom_range(1, 8));
      run_random(15);
    end
    set_all($urandom_range(1, 1024), $urandom_range(1, 255), 255);
    run_random(15);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n   = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    strip_len         = NUM_LEDS_RST;
    fade_amt          = FADE_STEP_RST;
    spawn_gap         = SPAWN_PERIOD_RST;
    ticks_since_spawn = '0;
    for (int i = 0; i < SLOTS; i++) begin
      lit[i]     = 1'b0;
      lit_led[i] = '0;
      lvl_red[i] = '0;
      lvl_grn[i] = '0;
      lvl_blu[i] = '0;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_registers();
    test_spawn_colours();
    test_deferred_spawn();
    test_no_fade();
    test_busy_strip();
    test_crowded_strip();
    test_random_settings();

    // Everything owed has arrived; give a stray extra beat time to show.
    wait_idle();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (pixel_q.size() != 0) begin
      $error("%0d expected beats never arrived", pixel_q.size());
      mismatches++;
    end

    if (mismatches == 0)
      $display("PASS led_twinkle_fader_core");
    else
      $display("FAIL led_twinkle_fader_core");
    $finish;
  end

endmodule
